@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// Guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PEMT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define PEMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ sv/pemt_pkg.sv @@
// Package for the pointer event mailbox throttle: payload structs,
// sizes, phase codes and controller states. No dependencies.
package pemt_pkg;
   localparam int QueueDepth = 8;
   localparam int ClockSlots = 4;
   localparam int QW = $clog2(QueueDepth);
   localparam int CW = $clog2(ClockSlots);

   typedef enum logic [1:0] {
      PH_DOWN = 2'd0, PH_MOVE = 2'd1, PH_UP = 2'd2, PH_CANCEL = 2'd3
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [47:0] now_us;
      logic [1:0]  phase;
      logic [7:0]  pointer_id;
      logic [15:0] owner_id;
      logic [7:0]  surface_id;
      logic [15:0] node_id;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  out_phase;
      logic [7:0]  out_pointer_id;
      logic [15:0] out_owner_id;
      logic [7:0]  out_surface_id;
      logic [15:0] out_node_id;
      logic [31:0] out_payload;
      logic        move_pending;
      logic        move_due;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [47:0] stream;
      logic [31:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_ACT, ST_STAT, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic scan;     // examine entry at scan index, advance
      logic act;      // apply the request
      logic stat;     // examine entry for status, advance
      logic clr_idx;  // restart index
      logic finish;   // build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;     // scan index at last relevant entry / none
   } sts_type;
endpackage

@@ sv/pointer_event_mailbox_throttle.sv @@
// Pointer event mailbox with per-pointer move throttling. Each transaction
// passes from acceptance to its result through these steps: one pass of
// the controller over the queued entries to find the coalesce, evict or take
// target, an act state that applies it, one pass to work out move_pending
// and move_due, then an output state with the result valid, in which the
// next transaction can already be taken once the result is not stalled.
// One transaction is in work at a time.
// Depends on pemt_pkg, pemt_ctrl, pemt_dp.
module pointer_event_mailbox_throttle (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pemt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pemt_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [23:0]       csr_data
);
   import pemt_pkg::*;
   cmd_type cmd;
   sts_type sts;

   pemt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );
   pemt_dp u_dp (
      .clock, .reset, .req_data, .csr_write, .csr_data, .cmd, .sts, .rsp_data
   );
endmodule

@@ sv/pemt_ctrl.sv @@
// Controller state machine for the mailbox: sequences scan, act and
// status passes over the queue. Depends on pemt_pkg.
module pemt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  pemt_pkg::sts_type sts,
   output pemt_pkg::cmd_type cmd
);
   import pemt_pkg::*;
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.clr_idx = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last) state_in = ST_ACT;
         end
         ST_ACT: begin
            cmd.act = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in = ST_STAT;
         end
         ST_STAT: begin
            cmd.stat = 1'b1;
            if (sts.last) begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  cmd.clr_idx = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

@@ sv/pemt_dp.sv @@
// Datapath for the mailbox: queue registers, clock table, scan
// registers and the result register. Depends on pemt_pkg.
module pemt_dp (
   input  logic              clock,
   input  logic              reset,
   input  pemt_pkg::req_type  req_data,
   input  logic              csr_write,
   input  logic [23:0]       csr_data,
   input  pemt_pkg::cmd_type  cmd,
   output pemt_pkg::sts_type  sts,
   output pemt_pkg::rsp_type  rsp_data
);
   import pemt_pkg::*;
   localparam logic [QW:0] Depth = (QW+1)'(QueueDepth);

   entry_type   q_ff [QueueDepth];
   logic [QW:0] cnt_ff;
   logic        ca_ff [ClockSlots];
   logic        ch_ff [ClockSlots];
   logic [7:0]  cid_ff [ClockSlots];
   logic [47:0] clst_ff [ClockSlots];
   logic [23:0] ival_ff;
   req_type     r_ff;
   logic [QW:0] idx_ff;
   // scan findings
   logic        edge_ff;            // any non-move queued
   logic        due_hit_ff;         // a due move found
   logic [QW:0] due_idx_ff;
   logic        newest_hit_ff;      // newest matching move (full push)
   logic [QW:0] newest_idx_ff;
   logic        old_hit_ff;         // oldest move
   logic [QW:0] old_idx_ff;
   logic        acc_ff;
   entry_type   tk_ff;
   logic        pend_ff, due_ff;
   rsp_type     rsp_ff;

   // helpers
   entry_type   cur;
   logic [QW-1:0] cur_i;
   logic        cur_move, cur_match, cur_due;
   logic [47:0] req_stream;
   logic [7:0]  cur_pid;
   logic        last_valid;

   assign req_stream = {r_ff.pointer_id, r_ff.owner_id, r_ff.surface_id, r_ff.node_id};
   assign cur_i = idx_ff[QW-1:0];
   assign cur = q_ff[cur_i];
   assign cur_move = cur.phase == PH_MOVE;
   assign cur_match = cur_move && cur.stream == req_stream;
   assign cur_pid = cur.stream[47:40];
   assign last_valid = idx_ff < cnt_ff;

   // due check of the entry under the index against the clock table
   always_comb begin
      cur_due = 1'b1;
      for (int s = 0; s < ClockSlots; s++) begin
         if (ca_ff[s] && cid_ff[s] == cur_pid && ch_ff[s] &&
             (r_ff.now_us - clst_ff[s]) < {24'd0, ival_ff})
            cur_due = 1'b0;
      end
   end

   assign sts.last = (idx_ff + 1'b1 >= cnt_ff) || !last_valid;

   // act stage selection
   logic        is_take;
   logic        sel_hit;
   logic [QW:0] sel_idx;
   entry_type   sel;
   logic [QW-1:0] tail_i;
   always_comb begin
      is_take = r_ff.kind;
      sel_hit = (cnt_ff != '0) && (edge_ff || due_hit_ff);
      sel_idx = edge_ff ? '0 : due_idx_ff;
      sel = q_ff[sel_idx[QW-1:0]];
      tail_i = QW'(cnt_ff - 1'b1);
   end

   // clock table lookups for the act stage
   logic [7:0]  act_pid;
   logic        fnd;
   logic [CW-1:0] fnd_s;
   logic        fre;
   logic [CW-1:0] fre_s;
   always_comb begin
      act_pid = is_take ? sel.stream[47:40] : r_ff.pointer_id;
      fnd = 1'b0; fnd_s = '0; fre = 1'b0; fre_s = '0;
      for (int s = ClockSlots-1; s >= 0; s--) begin
         if (ca_ff[s] && cid_ff[s] == act_pid) begin fnd = 1'b1; fnd_s = CW'(s); end
         if (!ca_ff[s]) begin fre = 1'b1; fre_s = CW'(s); end
      end
   end

   // sequential datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ival_ff <= '0;
         for (int s = 0; s < ClockSlots; s++) begin
            ca_ff[s] <= 1'b0;
            ch_ff[s] <= 1'b0;
         end
      end else begin
         if (csr_write) ival_ff <= csr_data;
         if (cmd.act) begin
            if (!is_take) begin
               // push
               if (r_ff.phase == PH_DOWN) begin
                  if (fnd) ch_ff[fnd_s] <= 1'b0;
                  else if (fre) begin
                     ca_ff[fre_s] <= 1'b1; ch_ff[fre_s] <= 1'b0;
                     cid_ff[fre_s] <= r_ff.pointer_id;
                  end
               end
               if (r_ff.phase == PH_MOVE) begin
                  if (cnt_ff != '0 && q_ff[tail_i].phase == PH_MOVE &&
                      q_ff[tail_i].stream == req_stream) begin
                     q_ff[tail_i] <= '{r_ff.phase, req_stream, r_ff.payload};
                  end else if (cnt_ff < Depth) begin
                     q_ff[cnt_ff[QW-1:0]] <= '{r_ff.phase, req_stream, r_ff.payload};
                     cnt_ff <= cnt_ff + 1'b1;
                  end else if (newest_hit_ff) begin
                     q_ff[newest_idx_ff[QW-1:0]] <= '{r_ff.phase, req_stream, r_ff.payload};
                  end
               end else if (cnt_ff < Depth) begin
                  q_ff[cnt_ff[QW-1:0]] <= '{r_ff.phase, req_stream, r_ff.payload};
                  cnt_ff <= cnt_ff + 1'b1;
               end else if (old_hit_ff) begin
                  // evict oldest move, shift down, append at the end
                  for (int i = 0; i < QueueDepth-1; i++)
                     if (i >= int'(old_idx_ff)) q_ff[i] <= q_ff[i+1];
                  q_ff[QueueDepth-1] <= '{r_ff.phase, req_stream, r_ff.payload};
               end
            end else if (sel_hit) begin
               // take: remove selected entry
               for (int i = 0; i < QueueDepth-1; i++)
                  if (i >= int'(sel_idx)) q_ff[i] <= q_ff[i+1];
               cnt_ff <= cnt_ff - 1'b1;
               if (sel.phase == PH_MOVE) begin
                  if (fnd) begin
                     ch_ff[fnd_s] <= 1'b1; clst_ff[fnd_s] <= r_ff.now_us;
                  end else if (fre) begin
                     ca_ff[fre_s] <= 1'b1; ch_ff[fre_s] <= 1'b1;
                     cid_ff[fre_s] <= act_pid; clst_ff[fre_s] <= r_ff.now_us;
                  end
               end else if (sel.phase != PH_DOWN && fnd) begin
                  ca_ff[fnd_s] <= 1'b0;
               end
            end
         end
      end
   end

   // scan and status registers
   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req_data;
      if (cmd.clr_idx) idx_ff <= '0;
      else if (cmd.scan || cmd.stat) idx_ff <= idx_ff + 1'b1;
      if (cmd.load) begin
         edge_ff <= 1'b0; due_hit_ff <= 1'b0; newest_hit_ff <= 1'b0;
         old_hit_ff <= 1'b0; due_idx_ff <= '0; newest_idx_ff <= '0; old_idx_ff <= '0;
      end
      if (cmd.scan && last_valid) begin
         if (!cur_move) edge_ff <= 1'b1;
         if (cur_move && cur_due && !due_hit_ff) begin
            due_hit_ff <= 1'b1; due_idx_ff <= idx_ff;
         end
         if (cur_match) begin newest_hit_ff <= 1'b1; newest_idx_ff <= idx_ff; end
         if (cur_move && !old_hit_ff) begin old_hit_ff <= 1'b1; old_idx_ff <= idx_ff; end
      end
      if (cmd.act) begin
         pend_ff <= 1'b0; due_ff <= 1'b0;
         tk_ff <= sel;
         if (is_take) acc_ff <= sel_hit;
         else if (r_ff.phase == PH_MOVE)
            acc_ff <= (cnt_ff != '0 && q_ff[tail_i].phase == PH_MOVE &&
                       q_ff[tail_i].stream == req_stream) || cnt_ff < Depth || newest_hit_ff;
         else acc_ff <= cnt_ff < Depth || old_hit_ff;
      end
      if (cmd.stat && last_valid && cur_move) begin
         pend_ff <= 1'b1;
         if (cur_due) due_ff <= 1'b1;
      end
      if (cmd.finish) begin
         rsp_ff.accepted <= acc_ff;
         rsp_ff.move_pending <= pend_ff || (last_valid && cur_move);
         rsp_ff.move_due <= due_ff || (last_valid && cur_move && cur_due);
         if (r_ff.kind && acc_ff) begin
            rsp_ff.out_phase <= tk_ff.phase;
            {rsp_ff.out_pointer_id, rsp_ff.out_owner_id,
             rsp_ff.out_surface_id, rsp_ff.out_node_id} <= tk_ff.stream;
            rsp_ff.out_payload <= tk_ff.payload;
         end else begin
            rsp_ff.out_phase <= '0; rsp_ff.out_pointer_id <= '0;
            rsp_ff.out_owner_id <= '0; rsp_ff.out_surface_id <= '0;
            rsp_ff.out_node_id <= '0; rsp_ff.out_payload <= '0;
         end
      end
   end

   assign rsp_data = rsp_ff;
endmodule

@@ sv/pemt_checker.sv @@
// Port-level checker for the mailbox, bound to the top level.
// Depends on pemt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pemt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pemt_pkg::rsp_type rsp_data
);
   import pemt_pkg::*;
   // held result stays put
   `PEMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // a due move implies a pending move
   `PEMT_ASSERT_IMP(a_due_pend, clock, reset, rsp_valid && rsp_data.move_due,
      rsp_data.move_pending)
   // no new transaction while a result is stalled
   `PEMT_ASSERT_IMP(a_no_accept, clock, reset, rsp_valid && rsp_stall, req_stall)
   // accepted transaction yields no result next cycle
   `PEMT_ASSERT_NEXT(a_lat, clock, reset, req_valid && !req_stall, !rsp_valid)
endmodule

bind pointer_event_mailbox_throttle pemt_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

@@ tb/testbench.sv @@
// Self-checking testbench for the pointer event mailbox throttle.
// Predicts each response with a software copy of the queue and clock table.
// Depends on pemt_pkg and pointer_event_mailbox_throttle.
module testbench;
   import pemt_pkg::*;

   // Software copy of the mailbox, with a queue of predicted responses
   class mailbox_scoreboard;
      logic [1:0]  q_phase [QueueDepth];
      logic [47:0] q_stream [QueueDepth];
      logic [31:0] q_payload [QueueDepth];
      int          q_count;
      bit          clk_active [ClockSlots];
      bit          clk_has [ClockSlots];
      logic [7:0]  clk_id [ClockSlots];
      logic [47:0] clk_last [ClockSlots];
      logic [23:0] interval;
      rsp_type     pending_rsp [$];
      int          mismatches;
      int          checked;

      function void clear();
         q_count = 0;
         interval = '0;
         mismatches = 0;
         checked = 0;
         for (int i = 0; i < ClockSlots; i++) begin
            clk_active[i] = 0;
            clk_has[i] = 0;
            clk_id[i] = '0;
            clk_last[i] = '0;
         end
      endfunction

      function int find_clock(logic [7:0] id);
         for (int i = 0; i < ClockSlots; i++)
            if (clk_active[i] && clk_id[i] == id) return i;
         return -1;
      endfunction

      function int find_or_make_clock(logic [7:0] id);
         int s;
         s = find_clock(id);
         if (s >= 0) return s;
         for (int i = 0; i < ClockSlots; i++)
            if (!clk_active[i]) begin
               clk_active[i] = 1;
               clk_has[i] = 0;
               clk_id[i] = id;
               clk_last[i] = '0;
               return i;
            end
         return -1;
      endfunction

      function bit clock_allows_move(logic [47:0] stream, logic [47:0] now);
         int s;
         logic [47:0] diff;
         s = find_clock(stream[47:40]);
         if (s < 0) return 1;
         if (!clk_has[s]) return 1;
         diff = now - clk_last[s];
         return diff >= {24'd0, interval};
      endfunction

      function void drop(int idx);
         for (int i = idx; i + 1 < q_count; i++) begin
            q_phase[i] = q_phase[i + 1];
            q_stream[i] = q_stream[i + 1];
            q_payload[i] = q_payload[i + 1];
         end
         q_count--;
      endfunction

      function void put(int idx, logic [1:0] ph, logic [47:0] st, logic [31:0] pl);
         q_phase[idx] = ph;
         q_stream[idx] = st;
         q_payload[idx] = pl;
      endfunction

      function bit push_event(logic [1:0] ph, logic [47:0] st, logic [31:0] pl);
         int s;
         if (ph == PH_DOWN) begin
            s = find_or_make_clock(st[47:40]);
            if (s >= 0) begin
               clk_has[s] = 0;
               clk_last[s] = '0;
            end
         end
         if (ph == PH_MOVE) begin
            if (q_count != 0 && q_phase[q_count - 1] == PH_MOVE
                && q_stream[q_count - 1] == st) begin
               put(q_count - 1, ph, st, pl);
               return 1;
            end
            if (q_count < QueueDepth) begin
               put(q_count, ph, st, pl);
               q_count++;
               return 1;
            end
            for (int i = q_count - 1; i >= 0; i--)
               if (q_phase[i] == PH_MOVE && q_stream[i] == st) begin
                  put(i, ph, st, pl);
                  return 1;
               end
            return 0;
         end
         // edge events evict the oldest move when full
         if (q_count >= QueueDepth) begin
            for (int i = 0; i < q_count; i++)
               if (q_phase[i] == PH_MOVE) begin
                  drop(i);
                  break;
               end
            if (q_count >= QueueDepth) return 0;
         end
         put(q_count, ph, st, pl);
         q_count++;
         return 1;
      endfunction

      // Notes an accepted request and queues its predicted response
      function void note_request(req_type r);
         rsp_type     e;
         bit          edge_seen;
         int          idx;
         int          s;
         logic [1:0]  ph;
         logic [47:0] st;
         e = '0;
         if (r.kind == 1'b0) begin
            e.accepted = push_event(r.phase,
               {r.pointer_id, r.owner_id, r.surface_id, r.node_id}, r.payload);
         end else if (q_count != 0) begin
            edge_seen = 0;
            idx = 0;
            for (int i = 0; i < q_count; i++)
               if (q_phase[i] != PH_MOVE) edge_seen = 1;
            if (!edge_seen) begin
               idx = q_count;
               for (int i = 0; i < q_count; i++)
                  if (clock_allows_move(q_stream[i], r.now_us)) begin
                     idx = i;
                     break;
                  end
            end
            if (idx < q_count) begin
               ph = q_phase[idx];
               st = q_stream[idx];
               e.accepted = 1;
               e.out_phase = ph;
               {e.out_pointer_id, e.out_owner_id, e.out_surface_id,
                e.out_node_id} = st;
               e.out_payload = q_payload[idx];
               drop(idx);
               if (ph == PH_MOVE) begin
                  s = find_or_make_clock(st[47:40]);
                  if (s >= 0) begin
                     clk_has[s] = 1;
                     clk_last[s] = r.now_us;
                  end
               end else if (ph != PH_DOWN) begin
                  s = find_clock(st[47:40]);
                  if (s >= 0) clk_active[s] = 0;
               end
            end
         end
         for (int i = 0; i < q_count; i++)
            if (q_phase[i] == PH_MOVE) begin
               e.move_pending = 1;
               if (clock_allows_move(q_stream[i], r.now_us)) e.move_due = 1;
            end
         pending_rsp.push_back(e);
      endfunction

      // Compares one accepted response with the oldest prediction
      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", a);
            return;
         end
         e = pending_rsp.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d mismatch: expected %h actual %h", checked, e, a);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [23:0] csr_data;

   mailbox_scoreboard board;
   int          cycle_count;
   int          items_sent;
   int          pushes_sent;
   int          takes_sent;
   logic [47:0] now_time;
   bit          stall_enable;
   int          rsp_hold;
   int          rsp_draw;

   pointer_event_mailbox_throttle DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   // 12 unit clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   // Response side: random wait per response, check on each accepted response
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         board.check_response(rsp_data);
         rsp_draw = stall_enable ? $urandom_range(0, 10) : 0;
         rsp_hold <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end else if (rsp_valid && rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_valid) begin
         rsp_hold <= 0;
         rsp_stall <= 1'b0;
      end
   end

   // Sends one transaction, after a random gap when gaps is set
   task automatic send_request(req_type r, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 10) : 0;
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      req_valid <= 1'b0;
      @(posedge clock);
      items_sent++;
      if (r.kind) takes_sent++;
      else pushes_sent++;
   endtask

   task automatic drain();
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_interval(logic [23:0] v);
      drain();
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      board.interval = v;
   endtask

   function automatic req_type make_push(logic [1:0] ph, logic [7:0] id,
                                         logic [31:0] pl);
      req_type r;
      r = '0;
      r.kind = 1'b0;
      r.now_us = 48'({$urandom, $urandom});
      r.phase = ph;
      r.pointer_id = id;
      r.owner_id = 16'h1234;
      r.surface_id = 8'h5;
      r.node_id = 16'h0042;
      r.payload = pl;
      return r;
   endfunction

   function automatic req_type make_take(logic [47:0] t);
      req_type r;
      r = {3'b000, $urandom, $urandom, $urandom, $urandom};
      r.kind = 1'b1;
      r.now_us = t;
      return r;
   endfunction

   // Random transaction: gesture-like streams on few pointers, plus noise
   function automatic req_type random_request();
      req_type r;
      int sel;
      r = {3'b000, $urandom, $urandom, $urandom, $urandom};
      sel = $urandom_range(0, 99);
      now_time = now_time + $urandom_range(0, 3000);
      if (sel < 5) now_time = 48'({$urandom, $urandom});
      r.now_us = now_time;
      if (sel < 45) begin
         r.kind = 1'b1;
      end else begin
         r.kind = 1'b0;
         if (sel < 90) begin
            r.pointer_id = 8'($urandom_range(0, 5));
            r.owner_id = 16'($urandom_range(0, 1));
            r.surface_id = 8'd3;
            r.node_id = 16'($urandom_range(0, 1));
            r.phase = (sel < 75) ? PH_MOVE : 2'($urandom_range(0, 3));
         end
      end
      return r;
   endfunction

   initial begin
      req_type r;
      logic [23:0] settings [4];
      board = new();
      board.clear();
      cycle_count = 0;
      items_sent = 0;
      pushes_sent = 0;
      takes_sent = 0;
      now_time = '0;
      stall_enable = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: take on empty, fill past depth, every phase, field extremes
      write_interval(24'd100);
      send_request(make_take(48'd0), 0);
      send_request(make_push(PH_DOWN, 8'd0, 32'hFFFF_FFFF), 0);
      r = make_push(PH_MOVE, 8'hFF, 32'h0);
      r.owner_id = 16'hFFFF;
      r.surface_id = 8'hFF;
      r.node_id = 16'hFFFF;
      send_request(r, 0);
      send_request(r, 0);
      for (int i = 1; i <= 6; i++) send_request(make_push(PH_MOVE, 8'(i), 32'(i)), 0);
      send_request(make_push(PH_MOVE, 8'hFF, 32'hA5A5), 1);
      send_request(make_push(PH_MOVE, 8'd9, 32'd9), 0);
      send_request(make_push(PH_UP, 8'd1, 32'd1), 0);
      send_request(make_push(PH_CANCEL, 8'd2, 32'd2), 0);
      for (int i = 0; i < 9; i++) send_request(make_take(48'hFFFF_FFFF_FFF0 + 48'(i)), 1);
      send_request(make_take(48'd50), 0);
      send_request(make_take(48'd200), 0);

      // Random phases under several intervals, extremes included
      stall_enable = 1'b1;
      settings[0] = 24'd0;
      settings[1] = 24'hFFFFFF;
      settings[2] = 24'd1500;
      settings[3] = 24'($urandom_range(1, 5000));
      for (int p = 0; p < 4; p++) begin
         write_interval(settings[p]);
         for (int i = 0; i < 410; i++) begin
            if (i == 200) drain();
            send_request(random_request(), (i % 100) < 70);
         end
      end

      drain();
      $display("covered %0d transactions: %0d pushes and %0d takes over %0d intervals",
               items_sent, pushes_sent, takes_sent, 5);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("mismatches: %0d", board.mismatches);
         $display("testbench failed");
      end
      $finish;
   end
endmodule
